// ===== design/pol_pkg.sv =====
// Shared types and constants for the positional ordered list.
`default_nettype none

package pol_pkg;

  localparam int unsigned DepthDef     = 64;
  localparam int unsigned DataWidthDef = 32;

  // Command codes as they arrive on cmd_i
  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_DELETE   = 3'd1,
    CMD_RETRIEVE = 3'd2,
    CMD_LOCATE   = 3'd3,
    CMD_PRIOR    = 3'd4,
    CMD_NEXT     = 3'd5,
    CMD_CLEAR    = 3'd6
  } cmd_e;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic rd_en;
    logic loc_en;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/pol_cell.sv =====
// One list entry cell: holds a word, shifts with its neighbours, flags reads and matches.
`default_nettype none

module pol_cell
  import pol_pkg::*;
#(
  parameter int unsigned DW  = DataWidthDef,
  parameter int unsigned PW  = 7,
  parameter int unsigned K   = 0
) (
  input  wire logic             clk_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [PW-1:0]    sh_idx_i,
  input  wire logic [PW-1:0]    rd_idx_i,
  input  wire logic [PW-1:0]    fill_i,
  input  wire logic [DW-1:0]    data_i,
  input  wire logic [DW-1:0]    left_i,
  input  wire logic [DW-1:0]    right_i,
  output logic      [DW-1:0]    word_o,
  output logic      [DW-1:0]    rd_word_o,
  output logic                  hit_o
);

  localparam logic [PW-1:0] MyIdx = PW'(K);

  logic [DW-1:0] word_q, word_d;
  logic [DW-1:0] rd_word_q;
  logic          hit_q;

  // Pick the next word: take from below on insert, from above on delete
  always_comb begin
    word_d = word_q;
    if (ctrl_i.shift_up) begin
      if (MyIdx == sh_idx_i) begin
        word_d = data_i;
      end else if (MyIdx > sh_idx_i) begin
        word_d = left_i;
      end
    end else if (ctrl_i.shift_down && (MyIdx >= sh_idx_i)) begin
      word_d = right_i;
    end
  end

  // Hold the entry and capture the gated read word and match flag
  always_ff @(posedge clk_i) begin
    word_q    <= word_d;
    rd_word_q <= (ctrl_i.rd_en && (MyIdx == rd_idx_i)) ? word_q : '0;
    hit_q     <= ctrl_i.loc_en && (MyIdx < fill_i) && (word_q == data_i);
  end

  assign word_o    = word_q;
  assign rd_word_o = rd_word_q;
  assign hit_o     = hit_q;

endmodule

`default_nettype wire

// ===== design/pol_reduce.sv =====
// Gathers the cell outputs: merges the read word and picks the first matching position.
`default_nettype none

module pol_reduce
  import pol_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef,
  parameter int unsigned DW    = DataWidthDef,
  parameter int unsigned CW    = 7
) (
  input  wire logic [DW-1:0] rd_word_i [DEPTH],
  input  wire logic          hit_i     [DEPTH],
  output logic      [DW-1:0] word_o,
  output logic      [CW-1:0] found_o,
  output logic               any_hit_o
);

  // Merge the gated words; at most one cell drives a non-zero value
  always_comb begin
    word_o = '0;
    for (int k = 0; k < DEPTH; k++) begin
      word_o = word_o | rd_word_i[k];
    end
  end

  // Lowest matching cell wins
  always_comb begin
    found_o   = '0;
    any_hit_o = 1'b0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (hit_i[k]) begin
        found_o   = CW'(k + 1);
        any_hit_o = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/positional_ordered_list.sv =====
// Top level of the positional ordered list: command sequencer and row of entry cells.
//
// Usage: present cmd_i, position_i and data_in_i with start high while busy is
// low; the command transaction is taken at that clock edge. Positions are
// 1-based. The list lives in a row of DEPTH cells, one word each; insert and
// delete shift all cells above the position together, reads and locate
// compare in every cell at once.
// The result appears on the result ports with done_o high for exactly one
// cycle, after the cell update or compare in ST_EXEC and then the gather of
// the cell outputs into the result registers in ST_RED.
// No new command is taken while busy; busy is low again in the cycle that
// shows the result, so the next command may be taken there.
// Every result carries the list length after the command and an empty flag.
// The receiver cannot hold results off; each result must be taken as shown.
// Reset empties the list (length zero) and returns to idle; stored words are
// not cleared and are only read once written.
`default_nettype none

module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int unsigned DEPTH      = DepthDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  localparam int unsigned PW = $clog2(DEPTH + 2),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [2:0]            cmd_i,
  input  wire logic [PW-1:0]         position_i,
  input  wire logic [DATA_WIDTH-1:0] data_in_i,
  output logic                       done_o,
  output logic                       status_o,
  output logic [DATA_WIDTH-1:0]      data_out_o,
  output logic [CW-1:0]              found_position_o,
  output logic [CW-1:0]              count_o,
  output logic                       is_empty_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RED  = 3'b100
  } state_e;

  state_e               state_q, state_d;
  cmd_e                 cmd_q;
  logic [PW-1:0]        pos_q;
  logic [DATA_WIDTH-1:0] data_q;
  logic [CW-1:0]        fill_q, fill_d;
  logic                 ok_q, ok_d;
  logic                 loc_q;

  logic                 done_q;
  logic                 status_q;
  logic [DATA_WIDTH-1:0] dout_q;
  logic [CW-1:0]        found_q;

  logic [PW-1:0]        fill_ext;
  logic [PW-1:0]        sh_idx;
  logic [PW-1:0]        rd_idx;
  logic                 ins_ok, del_ok, prior_ok, next_ok, rd_ok;
  logic                 is_exec;
  cell_ctrl_t           ctrl;

  logic [DATA_WIDTH-1:0] words    [DEPTH];
  logic [DATA_WIDTH-1:0] rd_words [DEPTH];
  logic                  hits     [DEPTH];
  logic [DATA_WIDTH-1:0] red_word;
  logic [CW-1:0]         red_found;
  logic                  red_any;

  assign is_exec  = (state_q == ST_EXEC);
  assign fill_ext = PW'(fill_q);
  assign sh_idx   = pos_q - PW'(1);

  // Check the position against the current length
  assign ins_ok   = (pos_q >= PW'(1)) && (pos_q <= fill_ext + PW'(1))
                    && (fill_q < CW'(DEPTH));
  assign del_ok   = (pos_q >= PW'(1)) && (pos_q <= fill_ext);
  assign prior_ok = (pos_q > PW'(1)) && (pos_q <= fill_ext);
  assign next_ok  = (pos_q >= PW'(1)) && (pos_q < fill_ext);

  // Decode the command into cell control, read index, new length and status
  always_comb begin
    ok_d   = 1'b0;
    rd_ok  = 1'b0;
    rd_idx = sh_idx;
    fill_d = fill_q;
    ctrl   = '0;
    unique case (cmd_q)
      CMD_INSERT: begin
        ok_d = ins_ok;
        ctrl.shift_up = is_exec && ins_ok;
        if (ins_ok) fill_d = fill_q + CW'(1);
      end
      CMD_DELETE: begin
        ok_d = del_ok;
        ctrl.shift_down = is_exec && del_ok;
        if (del_ok) fill_d = fill_q - CW'(1);
      end
      CMD_RETRIEVE: begin
        ok_d  = del_ok;
        rd_ok = del_ok;
      end
      CMD_LOCATE: begin
        ctrl.loc_en = is_exec;
      end
      CMD_PRIOR: begin
        ok_d   = prior_ok;
        rd_ok  = prior_ok;
        rd_idx = pos_q - PW'(2);
      end
      CMD_NEXT: begin
        ok_d   = next_ok;
        rd_ok  = next_ok;
        rd_idx = pos_q;
      end
      CMD_CLEAR: begin
        ok_d   = 1'b1;
        fill_d = '0;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    ctrl.rd_en = is_exec && rd_ok;
  end

  // Advance the sequencer: accept, update cells, gather results
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_RED;
      ST_RED:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

  // Hold control state and the list length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_RED);
      if (is_exec) fill_q <= fill_d;
    end
  end

  // Latch the command transaction, the pending status and the result registers
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start) begin
      cmd_q  <= cmd_e'(cmd_i);
      pos_q  <= position_i;
      data_q <= data_in_i;
    end
    if (is_exec) begin
      ok_q  <= ok_d;
      loc_q <= (cmd_q == CMD_LOCATE);
    end
    if (state_q == ST_RED) begin
      status_q <= loc_q ? !red_any : !ok_q;
      dout_q   <= red_word;
      found_q  <= red_found;
    end
  end

  // Row of entry cells
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = words[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = words[k+1];
    end
    pol_cell #(
      .DW (DATA_WIDTH),
      .PW (PW),
      .K  (k)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .sh_idx_i  (sh_idx),
      .rd_idx_i  (rd_idx),
      .fill_i    (fill_ext),
      .data_i    (data_q),
      .left_i    (left_w),
      .right_i   (right_w),
      .word_o    (words[k]),
      .rd_word_o (rd_words[k]),
      .hit_o     (hits[k])
    );
  end

  pol_reduce #(
    .DEPTH (DEPTH),
    .DW    (DATA_WIDTH),
    .CW    (CW)
  ) u_reduce (
    .rd_word_i (rd_words),
    .hit_i     (hits),
    .word_o    (red_word),
    .found_o   (red_found),
    .any_hit_o (red_any)
  );

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign data_out_o       = dout_q;
  assign found_position_o = found_q;
  assign count_o          = fill_q;
  assign is_empty_o       = (fill_q == '0);

endmodule

`default_nettype wire
